// ----- rtl/core/sqrtb_pkg.sv -----
// Package for the bisection square root core.
// Holds widths, FSM states, partial product selects and the MAC control struct.
// No dependencies.
package sqrtb_pkg;

  localparam int FRAC_BITS     = 16;
  localparam int RADICAND_BITS = 31;
  localparam int ROOT_W        = 32;
  localparam int SHIFT_W       = 5;
  localparam int BOUND_W       = RADICAND_BITS + FRAC_BITS;
  localparam int TARGET_W      = RADICAND_BITS + 2 * FRAC_BITS;
  localparam int SQ_W          = 2 * BOUND_W;
  localparam int HALF_LO_W     = (BOUND_W + 1) / 2;
  localparam int HALF_HI_W     = BOUND_W - HALF_LO_W;
  localparam int PROD_W        = 2 * HALF_LO_W;
  localparam int SHIFT_HL      = HALF_LO_W + 1;
  localparam int SHIFT_HH      = 2 * HALF_LO_W;

  localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(19);
  localparam logic [1:0]         MUL_LAST    = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_DECIDE,
    S_FINISH
  } state_t;

  typedef enum logic [1:0] {
    PP_LL,
    PP_HL,
    PP_HH
  } pp_sel_t;

  typedef struct packed {
    logic    clear;
    logic    mul_en;
    pp_sel_t sel;
    logic    acc_en;
  } mac_ctrl_t;

endpackage

// ----- rtl/core/sqrtb_mac.sv -----
// Shared multiply-accumulate unit: squares the midpoint from three half-width
// partial products, one multiply per cycle, product registered before the add.
// Depends on sqrtb_pkg.
module sqrtb_mac
  import sqrtb_pkg::*;
(
  input  logic                clk,
  input  mac_ctrl_t           ctrl,
  input  logic [BOUND_W-1:0]  mid,
  output logic [SQ_W-1:0]     acc
);

  logic [HALF_LO_W-1:0] op_lo;
  logic [HALF_LO_W-1:0] op_hi;
  logic [HALF_LO_W-1:0] op_a;
  logic [HALF_LO_W-1:0] op_b;
  logic [PROD_W-1:0]    prod_r;
  pp_sel_t              prod_sel_r;
  logic [SQ_W-1:0]      addend;
  logic [SQ_W-1:0]      acc_r;

  assign op_lo = mid[HALF_LO_W-1:0];
  assign op_hi = HALF_LO_W'(mid[BOUND_W-1:HALF_LO_W]);

  always_comb begin
    unique case (ctrl.sel)
      PP_LL: begin
        op_a = op_lo;
        op_b = op_lo;
      end
      PP_HL: begin
        op_a = op_hi;
        op_b = op_lo;
      end
      PP_HH: begin
        op_a = op_hi;
        op_b = op_hi;
      end
      default: begin
        op_a = op_lo;
        op_b = op_lo;
      end
    endcase
  end

  always_comb begin
    unique case (prod_sel_r)
      PP_LL:   addend = SQ_W'(prod_r);
      PP_HL:   addend = SQ_W'(prod_r) << SHIFT_HL;
      PP_HH:   addend = SQ_W'(prod_r) << SHIFT_HH;
      default: addend = SQ_W'(prod_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r     <= op_a * op_b;
      prod_sel_r <= ctrl.sel;
    end
    if (ctrl.clear) begin
      acc_r <= '0;
    end else if (ctrl.acc_en) begin
      acc_r <= acc_r + addend;
    end
  end

  assign acc = acc_r;

endmodule

// ----- rtl/core/sqrt_bisection_core.sv -----
// Top level of the bisection square root core: sequencer, bounds and word ports.
// Depends on sqrtb_pkg and sqrtb_mac.
//
//  channel | ports                          | word
//  in      | in_valid, in_ready, in_radicand| 31-bit unsigned radicand
//  out     | out_valid, out_ready, out_root | 32-bit unsigned Q16.16 root
//  cfg     | cfg_wr_en, cfg_wr_data         | 5-bit precision shift
//
// Radicand 0 or 1: the sequencer goes from idle straight to the result load. Otherwise
// it first runs N bisection steps (0 to 47, set by radicand and shift), each one a range
// check, three products and one trailing add on the shared 24x24 multiply-accumulate
// and one compare; a last range check precedes the result load.
// One word at a time: in_ready is high only when idle.
// A finished word waits in the sequencer while the output register holds an untaken
// result. Reset is synchronous and active low; the shift register resets to 19.
module sqrt_bisection_core
  import sqrtb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [RADICAND_BITS-1:0] in_radicand,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [ROOT_W-1:0]        out_root,
  input  logic                     cfg_wr_en,
  input  logic [SHIFT_W-1:0]       cfg_wr_data
);

  localparam logic [BOUND_W-1:0] LOWER_INIT = BOUND_W'(1) << FRAC_BITS;

  state_t               state_r, state_nxt;
  logic [1:0]           step_r, step_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [ROOT_W-1:0]    out_root_r, out_root_nxt;
  logic [SHIFT_W-1:0]   shift_r;
  logic [BOUND_W-1:0]   lower_r, lower_nxt;
  logic [BOUND_W-1:0]   upper_r, upper_nxt;
  logic [BOUND_W-1:0]   mid_r, mid_nxt;
  logic [TARGET_W-1:0]  target_r, target_nxt;
  logic [BOUND_W-1:0]   gap;
  logic [BOUND_W:0]     bound_sum;
  logic                 stop;
  logic                 too_big;
  logic [SQ_W-1:0]      acc;
  mac_ctrl_t            mac_ctrl;

  sqrtb_mac u_mac (
    .clk  (clk),
    .ctrl (mac_ctrl),
    .mid  (mid_r),
    .acc  (acc)
  );

  assign gap       = upper_r - lower_r;
  assign bound_sum = {1'b0, lower_r} + {1'b0, upper_r};
  assign stop      = (gap <= BOUND_W'(1)) || (gap <= (upper_r >> shift_r));
  assign too_big   = acc > SQ_W'(target_r);

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    lower_nxt     = lower_r;
    upper_nxt     = upper_r;
    mid_nxt       = mid_r;
    target_nxt    = target_r;
    out_root_nxt  = out_root_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mac_ctrl      = '{clear: 1'b0, mul_en: 1'b0, sel: PP_LL, acc_en: 1'b0};
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          lower_nxt  = LOWER_INIT;
          upper_nxt  = BOUND_W'(in_radicand) << FRAC_BITS;
          target_nxt = {in_radicand, (2 * FRAC_BITS)'(0)};
          state_nxt  = (in_radicand <= RADICAND_BITS'(1)) ? S_FINISH : S_CHECK;
        end
      end
      S_CHECK: begin
        if (stop) begin
          state_nxt = S_FINISH;
        end else begin
          mid_nxt        = bound_sum[BOUND_W:1];
          mac_ctrl.clear = 1'b1;
          step_nxt       = '0;
          state_nxt      = S_MUL;
        end
      end
      S_MUL: begin
        mac_ctrl.mul_en = (step_r != MUL_LAST);
        mac_ctrl.acc_en = (step_r != 2'd0);
        unique case (step_r)
          2'd0:    mac_ctrl.sel = PP_LL;
          2'd1:    mac_ctrl.sel = PP_HL;
          2'd2:    mac_ctrl.sel = PP_HH;
          default: mac_ctrl.sel = PP_LL;
        endcase
        step_nxt = step_r + 2'd1;
        if (step_r == MUL_LAST) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (too_big) begin
          upper_nxt = mid_r;
        end else begin
          lower_nxt = mid_r;
        end
        state_nxt = S_CHECK;
      end
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_root_nxt  = upper_r[ROOT_W-1:0];
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      shift_r     <= SHIFT_RESET;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        shift_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    lower_r    <= lower_nxt;
    upper_r    <= upper_nxt;
    mid_r      <= mid_nxt;
    target_r   <= target_nxt;
    out_root_r <= out_root_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_root  = out_root_r;

`ifndef ASSERT_OFF
  a_mid_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE) |-> (lower_r < mid_r) && (mid_r < upper_r))
    else $error("midpoint outside bounds");

  a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK) |-> (lower_r <= upper_r))
    else $error("lower bound above upper bound");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("ready while a word is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_root))
    else $error("stalled result changed");
`endif

endmodule
